// ----- sv/qmr_pkg.sv -----
`default_nettype none

package qmr_pkg;

    // Field widths
    localparam int ELEM_W = 32;
    localparam int QUAT_W = 16;
    localparam int ROT_W  = 26;   // rotation coefficients, hold 1 - 2(aa+bb) at 14 fraction bits
    localparam int PROD_W = ELEM_W + ROT_W;
    localparam int ACC_W  = PROD_W + 2;

    // Opcodes
    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_ROTATE = 1'b1;

    localparam logic [1:0] ROW_LAST = 2'd2;
    localparam logic [1:0] COL_LAST = 2'd2;

    // Quaternion component indexes
    typedef logic [1:0] t_qidx;
    localparam t_qidx Q_W = 2'd0;
    localparam t_qidx Q_X = 2'd1;
    localparam t_qidx Q_Y = 2'd2;
    localparam t_qidx Q_Z = 2'd3;

    // Doubled product order: xx yy zz xy xz yz wx wy wz
    localparam int D_XX = 0;
    localparam int D_YY = 1;
    localparam int D_ZZ = 2;
    localparam int D_XY = 3;
    localparam int D_XZ = 4;
    localparam int D_YZ = 5;
    localparam int D_WX = 6;
    localparam int D_WY = 7;
    localparam int D_WZ = 8;
    localparam logic [3:0] D_LAST = 4'd8;

    localparam t_qidx QA_SEL [0:8] = '{Q_X, Q_Y, Q_Z, Q_X, Q_X, Q_Y, Q_W, Q_W, Q_W};
    localparam t_qidx QB_SEL [0:8] = '{Q_X, Q_Y, Q_Z, Q_Y, Q_Z, Q_Z, Q_X, Q_Y, Q_Z};

    typedef struct packed {
        logic                     opcode;
        logic [1:0]               row_sel;
        logic signed [ELEM_W-1:0] elem_a;
        logic signed [ELEM_W-1:0] elem_b;
        logic signed [ELEM_W-1:0] elem_c;
        logic signed [QUAT_W-1:0] quat_w;
        logic signed [QUAT_W-1:0] quat_x;
        logic signed [QUAT_W-1:0] quat_y;
        logic signed [QUAT_W-1:0] quat_z;
    } t_in_item;

    typedef struct packed {
        logic [1:0]               out_row;
        logic signed [ELEM_W-1:0] out_a;
        logic signed [ELEM_W-1:0] out_b;
        logic signed [ELEM_W-1:0] out_c;
        logic                     saturated;
        logic                     last_row;
    } t_out_item;

    // MAC issue control
    typedef struct packed {
        logic vld;
        logic first;
        logic last;
    } t_mac_ctl;

endpackage

`default_nettype wire

// ----- sv/qmr_if.sv -----
`default_nettype none

interface qmr_in_if import qmr_pkg::*;;
    logic     valid;
    logic     ready;
    t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface qmr_out_if import qmr_pkg::*;;
    logic      valid;
    logic      ready;
    t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- sv/qmr_mac.sv -----
`default_nettype none

// Shared multiply-accumulate: product register, then accumulator.
// o_res_vld pulses when the accumulator holds a finished sum.
module qmr_mac import qmr_pkg::*; (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  t_mac_ctl                 i_ctl,
    input  wire signed [ELEM_W-1:0]  i_a,
    input  wire signed [ROT_W-1:0]   i_b,
    output logic signed [ACC_W-1:0]  o_acc,
    output logic                     o_res_vld
);

    logic signed [PROD_W-1:0] r_prod;
    t_mac_ctl                 r_pctl;
    logic signed [ACC_W-1:0]  r_acc;
    logic                     r_res_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pctl    <= '0;
            r_res_vld <= 1'b0;
        end else begin
            r_pctl    <= i_ctl;
            r_res_vld <= r_pctl.vld & r_pctl.last;
        end
        r_prod <= i_a * i_b;
        if (r_pctl.vld) begin
            r_acc <= (r_pctl.first ? '0 : r_acc)
                   + $signed({{(ACC_W-PROD_W){r_prod[PROD_W-1]}}, r_prod});
        end
    end

    assign o_acc     = r_acc;
    assign o_res_vld = r_res_vld;

endmodule

`default_nettype wire

// ----- sv/quaternion_matrix_rotate.sv -----
// Load transaction: the row is written at the accepting edge.
// Rotate transaction: the first row follows the doubled products and the matrix build,
// then each further row follows its own nine products plus any output stall.
// Its length is set by the single shared multiply-accumulate unit: 9 doubled products
// plus 27 matrix products, one issue per cycle within a batch, and a MAC drain per batch.
// Reset (synchronous, active low) sets the matrix to identity and idles the sequencer.
`default_nettype none

module quaternion_matrix_rotate import qmr_pkg::*; #(
    parameter int MATRIX_FRAC_BITS = 16,
    parameter int QUAT_FRAC_BITS   = 14
) (
    input  wire          i_clk,
    input  wire          i_rst_n,
    qmr_in_if.sink       i_in,
    qmr_out_if.source    o_out
);

    // Sequencer states:
    //   S_QUAT  issue the nine doubled quaternion products
    //   S_QWAIT drain the MAC
    //   S_BUILD form the rotation matrix from the products
    //   S_ROW   issue the nine products of one output row (3 sums of 3)
    //   S_RWAIT drain the MAC, last element lands the row
    //   S_OUT   hold the row until the sink takes it
    typedef enum logic [2:0] {
        S_IDLE, S_QUAT, S_QWAIT, S_BUILD, S_ROW, S_RWAIT, S_OUT
    } t_state;

    localparam logic signed [ELEM_W-1:0] M_ONE   = ELEM_W'(1) << MATRIX_FRAC_BITS;
    localparam logic signed [ROT_W-1:0]  Q_ONE   = ROT_W'(1) << QUAT_FRAC_BITS;
    localparam logic signed [ELEM_W-1:0] SAT_MAX = {1'b0, {(ELEM_W-1){1'b1}}};
    localparam logic signed [ELEM_W-1:0] SAT_MIN = {1'b1, {(ELEM_W-1){1'b0}}};

    t_state r_state;

    // Matrix store, row-major
    logic signed [ELEM_W-1:0] r_mat [0:2][0:2];
    // Rotation matrix and doubled products
    logic signed [ROT_W-1:0]  r_rot [0:2][0:2];
    logic signed [ROT_W-1:0]  r_d   [0:8];
    logic signed [QUAT_W-1:0] r_q   [0:3];

    // Issue and capture counters
    logic [3:0] r_qi;     // quaternion product issue
    logic [3:0] r_qc;     // quaternion product capture
    logic [1:0] r_row;
    logic [1:0] r_j;      // output column being issued
    logic [1:0] r_k;      // inner product term
    logic [1:0] r_col;    // output column being captured

    logic signed [ELEM_W-1:0] r_nrow [0:1];
    logic                     r_sat;

    logic      r_out_vld;
    t_out_item r_out;

    // MAC hookup
    t_mac_ctl                mac_ctl;
    logic signed [ELEM_W-1:0] mac_a;
    logic signed [ROT_W-1:0]  mac_b;
    logic signed [ACC_W-1:0]  mac_acc;
    logic                     mac_res_vld;

    always_comb begin
        mac_ctl.vld   = (r_state == S_QUAT) || (r_state == S_ROW);
        mac_ctl.first = (r_state == S_QUAT) || (r_k == 2'd0);
        mac_ctl.last  = (r_state == S_QUAT) || (r_k == COL_LAST);
        if (r_state == S_QUAT) begin
            mac_a = {{(ELEM_W-QUAT_W){r_q[QA_SEL[r_qi]][QUAT_W-1]}}, r_q[QA_SEL[r_qi]]};
            mac_b = {{(ROT_W-QUAT_W){r_q[QB_SEL[r_qi]][QUAT_W-1]}}, r_q[QB_SEL[r_qi]]};
        end else begin
            mac_a = r_mat[r_row][r_k];
            mac_b = r_rot[r_k][r_j];
        end
    end

    qmr_mac u_mac (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (mac_ctl),
        .i_a       (mac_a),
        .i_b       (mac_b),
        .o_acc     (mac_acc),
        .o_res_vld (mac_res_vld)
    );

    // Doubled product: 2ab truncated by the quaternion fraction bits
    logic signed [ACC_W-1:0] d_dbl;
    logic signed [ACC_W-1:0] d_sh;
    logic signed [ROT_W-1:0] d_val;

    // Matrix element: truncate, then clamp to 32 bits
    logic signed [ACC_W-1:0]     e_sh;
    logic [ACC_W-ELEM_W:0]       e_hi;
    logic                        e_ovf;
    logic signed [ELEM_W-1:0]    e_val;

    always_comb begin
        d_dbl = mac_acc <<< 1;
        d_sh  = d_dbl >>> QUAT_FRAC_BITS;
        d_val = d_sh[ROT_W-1:0];

        e_sh  = mac_acc >>> QUAT_FRAC_BITS;
        e_hi  = e_sh[ACC_W-1:ELEM_W-1];
        e_ovf = !((&e_hi) || !(|e_hi));
        if (e_ovf) begin
            e_val = e_sh[ACC_W-1] ? SAT_MIN : SAT_MAX;
        end else begin
            e_val = e_sh[ELEM_W-1:0];
        end
    end

    // Rotation matrix from the doubled products
    logic signed [ROT_W-1:0] rot_new [0:2][0:2];

    always_comb begin
        rot_new[0][0] = Q_ONE - r_d[D_YY] - r_d[D_ZZ];
        rot_new[0][1] = r_d[D_XY] + r_d[D_WZ];
        rot_new[0][2] = r_d[D_XZ] - r_d[D_WY];
        rot_new[1][0] = r_d[D_XY] - r_d[D_WZ];
        rot_new[1][1] = Q_ONE - r_d[D_XX] - r_d[D_ZZ];
        rot_new[1][2] = r_d[D_YZ] + r_d[D_WX];
        rot_new[2][0] = r_d[D_XZ] + r_d[D_WY];
        rot_new[2][1] = r_d[D_YZ] - r_d[D_WX];
        rot_new[2][2] = Q_ONE - r_d[D_XX] - r_d[D_YY];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_out_vld <= 1'b0;
            r_qi      <= '0;
            r_qc      <= '0;
            r_row     <= '0;
            r_j       <= '0;
            r_k       <= '0;
            r_col     <= '0;
            r_sat     <= 1'b0;
            for (int i = 0; i < 3; i++) begin
                for (int c = 0; c < 3; c++) begin
                    r_mat[i][c] <= (i == c) ? M_ONE : '0;
                end
            end
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_in.valid) begin
                        if (i_in.data.opcode == OP_ROTATE) begin
                            r_q[Q_W] <= i_in.data.quat_w;
                            r_q[Q_X] <= i_in.data.quat_x;
                            r_q[Q_Y] <= i_in.data.quat_y;
                            r_q[Q_Z] <= i_in.data.quat_z;
                            r_qi     <= '0;
                            r_qc     <= '0;
                            r_state  <= S_QUAT;
                        end else if (i_in.data.row_sel <= ROW_LAST) begin
                            // a row select past the last row is dropped
                            r_mat[i_in.data.row_sel][0] <= i_in.data.elem_a;
                            r_mat[i_in.data.row_sel][1] <= i_in.data.elem_b;
                            r_mat[i_in.data.row_sel][2] <= i_in.data.elem_c;
                        end
                    end
                end
                S_QUAT: begin
                    r_qi <= r_qi + 4'd1;
                    if (r_qi == D_LAST) begin
                        r_state <= S_QWAIT;
                    end
                end
                S_QWAIT: begin
                    // leaves on the last capture below
                end
                S_BUILD: begin
                    r_rot   <= rot_new;
                    r_row   <= '0;
                    r_j     <= '0;
                    r_k     <= '0;
                    r_col   <= '0;
                    r_sat   <= 1'b0;
                    r_state <= S_ROW;
                end
                S_ROW: begin
                    if (r_k == COL_LAST) begin
                        r_k <= '0;
                        r_j <= r_j + 2'd1;
                        if (r_j == COL_LAST) begin
                            r_state <= S_RWAIT;
                        end
                    end else begin
                        r_k <= r_k + 2'd1;
                    end
                end
                S_RWAIT: begin
                    // leaves when the row's last element lands
                end
                S_OUT: begin
                    if (o_out.ready) begin
                        r_out_vld <= 1'b0;
                        r_sat     <= 1'b0;
                        if (r_row == ROW_LAST) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_row   <= r_row + 2'd1;
                            r_j     <= '0;
                            r_k     <= '0;
                            r_state <= S_ROW;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase

            // MAC result capture
            if (mac_res_vld && ((r_state == S_QUAT) || (r_state == S_QWAIT))) begin
                r_d[r_qc] <= d_val;
                r_qc      <= r_qc + 4'd1;
                if (r_qc == D_LAST) begin
                    r_state <= S_BUILD;
                end
            end
            if (mac_res_vld && ((r_state == S_ROW) || (r_state == S_RWAIT))) begin
                if (r_col == COL_LAST) begin
                    // row complete: write back and present it
                    r_mat[r_row][0]   <= r_nrow[0];
                    r_mat[r_row][1]   <= r_nrow[1];
                    r_mat[r_row][2]   <= e_val;
                    r_out.out_row     <= r_row;
                    r_out.out_a       <= r_nrow[0];
                    r_out.out_b       <= r_nrow[1];
                    r_out.out_c       <= e_val;
                    r_out.saturated   <= r_sat | e_ovf;
                    r_out.last_row    <= (r_row == ROW_LAST);
                    r_out_vld         <= 1'b1;
                    r_col             <= '0;
                    r_state           <= S_OUT;
                end else begin
                    r_nrow[r_col[0]] <= e_val;
                    r_sat            <= r_sat | e_ovf;
                    r_col            <= r_col + 2'd1;
                end
            end
        end
    end

    assign i_in.ready  = (r_state == S_IDLE);
    assign o_out.valid = r_out_vld;
    assign o_out.data  = r_out;

    // The MAC is idle whenever the sequencer is.
    a_mac_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !mac_res_vld)
        else $error("MAC result while sequencer idle");

    // A result never waits while a new transaction can be taken.
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in.ready |-> !o_out.valid)
        else $error("input ready while a row is pending");

    // Last flag marks row two only.
    a_last_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (o_out.data.last_row == (o_out.data.out_row == ROW_LAST)))
        else $error("last_row flag inconsistent with out_row");

    // Taking the last row returns the block to idle.
    a_end_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.ready && o_out.data.last_row) |=> i_in.ready)
        else $error("block not idle after last row");

endmodule

`default_nettype wire
